// ----- design/tick_slot_event_table_macros.svh -----
// ---------------------------------------------------------------------------
// Tick slot event table assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef TICK_SLOT_EVENT_TABLE_MACROS_SVH
`define TICK_SLOT_EVENT_TABLE_MACROS_SVH

// A property that must hold at every clock edge out of reset.
`define TSET_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A condition that must be followed by a consequence in the next cycle.
`define TSET_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/tset_pkg.sv -----
// ---------------------------------------------------------------------------
// Tick slot event table package
// Payload types, operation codes and controller interface structs.
// ---------------------------------------------------------------------------
package tset_pkg;

  localparam int DEF_SLOTS       = 3840;
  localparam int DEF_PROBE_LIMIT = 5;
  localparam int STEPS           = 16;

  localparam logic [7:0] NOTE_ON_RST = 8'd144;

  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_CLEAR  = 2'd1;
  localparam logic [1:0] MODE_SCAN   = 2'd2;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] tick;
    logic [7:0]  ev_code;
    logic [7:0]  note;
    logic [7:0]  velocity;
    logic [15:0] hold_ms;
  } in_item_t;

  typedef struct packed {
    logic        stored;
    logic [11:0] slot_used;
    logic [15:0] step_bitmap;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  ev_code;
    logic [7:0]  note;
    logic [7:0]  velocity;
    logic [15:0] hold_ms;
  } slot_t;

  typedef struct packed {
    logic load_item;
    logic zero_wr;
    logic addr_from_rem;
    logic probe_rd;
    logic probe_wr;
    logic probe_next;
    logic clr_start;
    logic scan_start;
    logic scan_rd;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       addr_last;
    logic       tick_in_range;
    logic       slot_empty;
    logic       probe_last;
    logic       scan_last;
    logic       out_free;
  } ctrl_sts_t;

endpackage

// ----- design/tset_dp.sv -----
// ---------------------------------------------------------------------------
// Tick slot event table datapath
// Slot memory, tick reduction, address and step counters, result registers.
// ---------------------------------------------------------------------------
`include "tick_slot_event_table_macros.svh"

module tset_dp
  import tset_pkg::*;
#(
  parameter int SLOTS       = DEF_SLOTS,
  parameter int PROBE_LIMIT = DEF_PROBE_LIMIT
) (
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_data,
  input  logic      out_stall,
  output logic      out_valid,
  output out_item_t out_data,
  input  logic      cfg_we,
  input  logic [7:0] cfg_wdata,
  input  ctrl_cmd_t cmd,
  output ctrl_sts_t sts
);

  localparam int AW  = $clog2(SLOTS);
  localparam int PW  = (PROBE_LIMIT > 1) ? $clog2(PROBE_LIMIT) : 1;
  localparam int PER = SLOTS / STEPS;
  localparam int WW  = (PER > 1) ? $clog2(PER) : 1;
  localparam longint unsigned RECIP_L = ((64'd1 << 32) + SLOTS - 1) / SLOTS;
  localparam logic [31:0] RECIP     = 32'(RECIP_L);
  localparam logic [3:0]  STEP_LAST = 4'(STEPS - 1);

  slot_t            mem [SLOTS];
  slot_t            rd_data_r;
  in_item_t         item_r;
  logic [47:0]      prod_r;
  logic [15:0]      qs_r;
  logic [15:0]      rem_raw;
  logic [15:0]      rem;
  logic [AW-1:0]    addr_r, addr_nxt, addr_wrap;
  logic [PW-1:0]    probe_cnt_r;
  logic [3:0]       step_r, rdstep_r;
  logic [WW-1:0]    within_r;
  logic             rdv_r;
  logic             stored_r;
  logic [AW-1:0]    slot_r;
  logic [15:0]      map_r;
  logic [7:0]       note_on_r;
  logic             out_valid_r;
  out_item_t        out_r;
  logic             wr_en, rd_en;
  slot_t            wr_data;

  assign rem_raw   = item_r.tick - qs_r;
  assign rem       = (rem_raw >= 16'(SLOTS)) ? rem_raw - 16'(SLOTS) : rem_raw;
  assign addr_wrap = (addr_r == AW'(SLOTS - 1)) ? '0 : addr_r + 1'b1;

  assign wr_en   = cmd.zero_wr || cmd.probe_wr;
  assign rd_en   = cmd.probe_rd || cmd.scan_rd;
  assign wr_data = cmd.zero_wr ? '0 :
                   {item_r.ev_code, item_r.note, item_r.velocity, item_r.hold_ms};

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr_r] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[addr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_r <= in_data;
    end
    prod_r <= 48'(item_r.tick) * 48'(RECIP);
    qs_r   <= 16'(32'(prod_r[47:32]) * 32'(SLOTS));
  end

  always_comb begin
    addr_nxt = addr_r;
    if (cmd.addr_from_rem) begin
      addr_nxt = rem[AW-1:0];
    end else if (cmd.clr_start) begin
      addr_nxt = item_r.tick[AW-1:0];
    end else if (cmd.scan_start) begin
      addr_nxt = '0;
    end else if (cmd.probe_next) begin
      addr_nxt = addr_wrap;
    end else if (cmd.zero_wr || cmd.scan_rd) begin
      addr_nxt = addr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r      <= '0;
      probe_cnt_r <= '0;
      step_r      <= '0;
      within_r    <= '0;
      rdv_r       <= 1'b0;
      note_on_r   <= NOTE_ON_RST;
      out_valid_r <= 1'b0;
    end else begin
      addr_r <= addr_nxt;
      rdv_r  <= cmd.scan_rd;
      if (cfg_we) begin
        note_on_r <= cfg_wdata;
      end
      if (cmd.addr_from_rem) begin
        probe_cnt_r <= '0;
      end else if (cmd.probe_next) begin
        probe_cnt_r <= probe_cnt_r + 1'b1;
      end
      if (cmd.scan_start) begin
        step_r   <= '0;
        within_r <= '0;
      end else if (cmd.scan_rd) begin
        if (within_r == WW'(PER - 1)) begin
          within_r <= '0;
          step_r   <= step_r + 1'b1;
        end else begin
          within_r <= within_r + 1'b1;
        end
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_rd) begin
      rdstep_r <= step_r;
    end
    if (cmd.load_item) begin
      stored_r <= 1'b0;
      slot_r   <= '0;
    end else if (cmd.probe_wr) begin
      stored_r <= 1'b1;
      slot_r   <= addr_r;
    end
    if (cmd.load_item || cmd.scan_start) begin
      map_r <= '0;
    end else if (rdv_r && rd_data_r.ev_code == note_on_r) begin
      map_r[STEP_LAST - rdstep_r] <= 1'b1;
    end
    if (cmd.out_load) begin
      out_r.stored      <= stored_r;
      out_r.slot_used   <= 12'(slot_r);
      out_r.step_bitmap <= map_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign sts.mode          = item_r.mode;
  assign sts.addr_last     = (addr_r == AW'(SLOTS - 1));
  assign sts.tick_in_range = ({1'b0, item_r.tick} < 17'(SLOTS));
  assign sts.slot_empty    = (rd_data_r.ev_code == 8'd0);
  assign sts.probe_last    = (probe_cnt_r == PW'(PROBE_LIMIT - 1));
  assign sts.scan_last     = (step_r == STEP_LAST) && (within_r == WW'(PER - 1));
  assign sts.out_free      = !out_valid_r || !out_stall;

  `TSET_ASSERT(a_no_rd_wr_same, !(wr_en && rd_en), "Memory read and write in one cycle.")
  `TSET_ASSERT(a_out_load_free, !cmd.out_load || !out_valid_r || !out_stall, "Result loaded over a held transfer.")
  `TSET_ASSERT(a_probe_bound, probe_cnt_r <= PW'(PROBE_LIMIT - 1), "Probe count beyond limit.")
  `TSET_ASSERT_NEXT(a_store_slot, cmd.probe_wr, stored_r && slot_r == $past(addr_r), "Stored slot not recorded.")

endmodule

// ----- design/tset_ctrl.sv -----
// ---------------------------------------------------------------------------
// Tick slot event table controller
// Sequences the clearing pass, insert probing, range clears and step scans.
// ---------------------------------------------------------------------------
module tset_ctrl
  import tset_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  ctrl_sts_t sts,
  output ctrl_cmd_t cmd
);

  localparam logic [3:0] S_INIT  = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_DISP  = 4'd2;
  localparam logic [3:0] S_MODA  = 4'd3;
  localparam logic [3:0] S_MODB  = 4'd4;
  localparam logic [3:0] S_PRD   = 4'd5;
  localparam logic [3:0] S_PCHK  = 4'd6;
  localparam logic [3:0] S_CLR   = 4'd7;
  localparam logic [3:0] S_SCAN  = 4'd8;
  localparam logic [3:0] S_DRAIN = 4'd9;
  localparam logic [3:0] S_RES   = 4'd10;

  logic [3:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_INIT: begin
        cmd.zero_wr = 1'b1;
        if (sts.addr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = S_DISP;
        end
      end
      S_DISP: begin
        case (sts.mode)
          MODE_INSERT: state_nxt = S_MODA;
          MODE_CLEAR: begin
            if (sts.tick_in_range) begin
              cmd.clr_start = 1'b1;
              state_nxt     = S_CLR;
            end else begin
              state_nxt = S_RES;
            end
          end
          MODE_SCAN: begin
            cmd.scan_start = 1'b1;
            state_nxt      = S_SCAN;
          end
          default: state_nxt = S_RES;
        endcase
      end
      S_MODA: state_nxt = S_MODB;
      S_MODB: begin
        cmd.addr_from_rem = 1'b1;
        state_nxt         = S_PRD;
      end
      S_PRD: begin
        cmd.probe_rd = 1'b1;
        state_nxt    = S_PCHK;
      end
      S_PCHK: begin
        if (sts.slot_empty) begin
          cmd.probe_wr = 1'b1;
          state_nxt    = S_RES;
        end else if (sts.probe_last) begin
          state_nxt = S_RES;
        end else begin
          cmd.probe_next = 1'b1;
          state_nxt      = S_PRD;
        end
      end
      S_CLR: begin
        cmd.zero_wr = 1'b1;
        if (sts.addr_last) begin
          state_nxt = S_RES;
        end
      end
      S_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (sts.scan_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: state_nxt = S_RES;
      S_RES: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// ----- design/tick_slot_event_table.sv -----
// ---------------------------------------------------------------------------
// Tick slot event table
// Bar-long table of tick slots with probing insert, range clear and step map.
// ---------------------------------------------------------------------------
// The input channel (in_valid, in_stall, in_data) takes one command at a time.
// Every command returns exactly one transfer on the result channel
// (out_valid, out_stall, out_data), held in an output register.
// An insert reduces the tick modulo SLOTS through the product and quotient
// registers, then reads and checks each probed slot in turn (S_PRD, S_PCHK)
// on the one memory read port, probing at most PROBE_LIMIT slots.
// A clear writes one slot per cycle from tick to the end of the bar; a tick
// past the end writes no slot and goes straight to its result.
// A step scan reads one slot per cycle over 16 * (SLOTS / 16) slots.
// The unused mode returns zeros.
// The next command is accepted in the cycle after a result is loaded, even
// while the receiver still stalls that result. A result waits in S_RES only
// when the previous one has not yet been taken.
// After reset the table is cleared one slot per cycle with in_stall high.
// The note-on code register must be written only while no command is in
// flight; the block itself does not enforce this.
// ---------------------------------------------------------------------------
module tick_slot_event_table
  import tset_pkg::*;
#(
  parameter int SLOTS       = DEF_SLOTS,
  parameter int PROBE_LIMIT = DEF_PROBE_LIMIT
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_item_t   in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output out_item_t  out_data,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata
);

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  tset_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  tset_dp #(
    .SLOTS       (SLOTS),
    .PROBE_LIMIT (PROBE_LIMIT)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule
